// ===== design/prdq_pkg.sv =====
`timescale 1ns / 1ps

package prdq_pkg;

   localparam int MAX_TASKS_DEF = 8;
   localparam int KIND_W        = 2;
   localparam int TASK_W        = 8;
   localparam int DELTA_W       = 16;
   localparam int STATUS_W      = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // Operation carried by a token as it travels down the row of cells.
   typedef enum logic [2:0] {
      TOK_NONE = 3'd0,
      TOK_DEC  = 3'd1,
      TOK_INS  = 3'd2,
      TOK_DISP = 3'd3,
      TOK_FIND = 3'd4,
      TOK_POP  = 3'd5,
      TOK_PULL = 3'd6
   } tok_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WAIT_ADD,
      ST_WAIT_REM,
      ST_WAIT_DEC,
      ST_CHECK,
      ST_WAIT_POP,
      ST_WAIT_REINS
   } state_type;

   typedef struct packed {
      logic               used;
      logic [TASK_W-1:0]  task_id;
      logic [DELTA_W-1:0] delta;
      logic [DELTA_W-1:0] period;
   } entry_type;

   typedef struct packed {
      tok_kind_type       kind;
      logic [TASK_W-1:0]  task_id;
      logic [DELTA_W-1:0] delta;
      logic [DELTA_W-1:0] period;
   } token_type;

   typedef struct packed {
      logic done;
      logic miss;
   } chain_stat_type;

endpackage

// ===== design/prdq_cell.sv =====
`timescale 1ns / 1ps

module prdq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  prdq_pkg::token_type      tok_in,
   input  prdq_pkg::entry_type      nxt,
   output prdq_pkg::entry_type      ent,
   output prdq_pkg::token_type      tok_out,
   output prdq_pkg::chain_stat_type stat
);
   import prdq_pkg::*;

   entry_type ent_ff;
   entry_type ent_in;
   token_type tok_ff;

   assign ent = ent_ff;

   always_comb begin
      ent_in  = ent_ff;
      tok_out = '0;
      stat    = '0;
      unique case (tok_ff.kind)
         TOK_DEC: begin
            if (ent_ff.used && ent_ff.delta != '0) begin
               ent_in.delta = ent_ff.delta - 1'b1;
            end
            stat.done = 1'b1;
         end
         TOK_INS: begin
            if (!ent_ff.used) begin
               ent_in    = '{1'b1, tok_ff.task_id, tok_ff.delta, tok_ff.period};
               stat.done = 1'b1;
            end else if (tok_ff.delta < ent_ff.delta) begin
               // The new entry lands here; the old one moves down with what is left.
               ent_in  = '{1'b1, tok_ff.task_id, tok_ff.delta, tok_ff.period};
               tok_out = '{TOK_DISP, ent_ff.task_id, ent_ff.delta - tok_ff.delta,
                           ent_ff.period};
            end else begin
               tok_out       = tok_ff;
               tok_out.delta = tok_ff.delta - ent_ff.delta;
            end
         end
         TOK_DISP: begin
            ent_in = '{1'b1, tok_ff.task_id, tok_ff.delta, tok_ff.period};
            if (!ent_ff.used) begin
               stat.done = 1'b1;
            end else begin
               tok_out = '{TOK_DISP, ent_ff.task_id, ent_ff.delta, ent_ff.period};
            end
         end
         TOK_FIND, TOK_POP: begin
            if (ent_ff.used && (tok_ff.kind == TOK_POP || ent_ff.task_id == tok_ff.task_id)) begin
               // Unlink this entry and fold its delta into the successor.
               if (nxt.used) begin
                  ent_in       = nxt;
                  ent_in.delta = ent_ff.delta + nxt.delta;
                  tok_out.kind = TOK_PULL;
               end else begin
                  ent_in.used = 1'b0;
                  stat.done   = 1'b1;
               end
            end else if (ent_ff.used) begin
               tok_out = tok_ff;
            end else begin
               stat.miss = 1'b1;
            end
         end
         TOK_PULL: begin
            if (nxt.used) begin
               ent_in       = nxt;
               tok_out.kind = TOK_PULL;
            end else begin
               ent_in.used = 1'b0;
               stat.done   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.used <= 1'b0;
         tok_ff.kind <= TOK_NONE;
      end else begin
         ent_ff <= ent_in;
         tok_ff <= tok_in;
      end
   end

endmodule

// ===== design/prdq_ctrl.sv =====
`timescale 1ns / 1ps

module prdq_ctrl #(
   parameter int MAX_TASKS = prdq_pkg::MAX_TASKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [prdq_pkg::KIND_W-1:0]     req_kind,
   input  logic [prdq_pkg::TASK_W-1:0]     req_task_id,
   input  logic [prdq_pkg::DELTA_W-1:0]    req_first_delay,
   input  logic [prdq_pkg::DELTA_W-1:0]    req_period,
   input  prdq_pkg::entry_type             head,
   input  prdq_pkg::chain_stat_type        chain_stat,
   output prdq_pkg::token_type             launch,
   output logic                            rsp_valid,
   output logic [prdq_pkg::TASK_W-1:0]     rsp_released_task,
   output logic                            rsp_released_valid,
   output logic [prdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_last
);
   import prdq_pkg::*;

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TASK_W-1:0]     rel_task_ff, rel_task_in;
   logic [DELTA_W-1:0]    rel_period_ff, rel_period_in;
   logic                  pend_ff, pend_in;
   logic                  any_ff, any_in;
   logic                  valid_ff, valid_in;
   logic [TASK_W-1:0]     task_ff, task_in;
   logic                  rvalid_ff, rvalid_in;
   status_type            status_ff, status_in;
   logic                  last_ff, last_in;
   logic [DELTA_W-1:0]    delay_fix, period_fix;
   logic                  head_due;

   assign delay_fix  = (req_first_delay == '0) ? DELTA_W'(1) : req_first_delay;
   assign period_fix = (req_period == '0) ? DELTA_W'(1) : req_period;
   assign head_due   = head.used && (head.delta == '0);

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_released_task  = task_ff;
   assign rsp_released_valid = rvalid_ff;
   assign rsp_status         = status_ff;
   assign rsp_last           = last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rel_task_in   = rel_task_ff;
      rel_period_in = rel_period_ff;
      pend_in       = pend_ff;
      any_in        = any_ff;
      launch        = '0;
      valid_in      = 1'b0;
      task_in       = '0;
      rvalid_in     = 1'b0;
      status_in     = STATUS_OK;
      last_in       = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (kind_type'(req_kind))
                  KIND_ADD: begin
                     if (count_ff == CNT_W'(MAX_TASKS)) begin
                        valid_in  = 1'b1;
                        status_in = STATUS_FULL;
                     end else begin
                        launch   = '{TOK_INS, req_task_id, delay_fix, period_fix};
                        count_in = count_ff + 1'b1;
                        state_in = ST_WAIT_ADD;
                     end
                  end
                  KIND_REMOVE: begin
                     launch.kind    = TOK_FIND;
                     launch.task_id = req_task_id;
                     state_in       = ST_WAIT_REM;
                  end
                  KIND_TICK: begin
                     launch.kind = TOK_DEC;
                     pend_in     = 1'b0;
                     any_in      = 1'b0;
                     state_in    = ST_WAIT_DEC;
                  end
                  KIND_NOP: begin
                     valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WAIT_ADD: begin
            if (chain_stat.done) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WAIT_REM: begin
            if (chain_stat.done) begin
               valid_in = 1'b1;
               count_in = count_ff - 1'b1;
               state_in = ST_IDLE;
            end else if (chain_stat.miss) begin
               valid_in  = 1'b1;
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_IDLE;
            end
         end
         ST_WAIT_DEC: begin
            if (chain_stat.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // A finished release is reported here, once the head shows
            // whether another entry falls due on the same tick.
            if (pend_ff) begin
               valid_in  = 1'b1;
               task_in   = rel_task_ff;
               rvalid_in = 1'b1;
               last_in   = !head_due;
            end
            pend_in = 1'b0;
            if (head_due) begin
               rel_task_in   = head.task_id;
               rel_period_in = head.period;
               launch.kind   = TOK_POP;
               any_in        = 1'b1;
               state_in      = ST_WAIT_POP;
            end else begin
               if (!any_ff) begin
                  valid_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_WAIT_POP: begin
            if (chain_stat.done) begin
               launch   = '{TOK_INS, rel_task_ff, rel_period_ff, rel_period_ff};
               state_in = ST_WAIT_REINS;
            end
         end
         ST_WAIT_REINS: begin
            if (chain_stat.done) begin
               pend_in  = 1'b1;
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         any_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         any_ff   <= any_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_task_ff   <= rel_task_in;
      rel_period_ff <= rel_period_in;
      task_ff       <= task_in;
      rvalid_ff     <= rvalid_in;
      status_ff     <= status_in;
      last_ff       <= last_in;
   end

endmodule

// ===== design/periodic_release_delta_queue_core.sv =====
`timescale 1ns / 1ps

// Periodic release queue kept as a delta-sorted list in a row of cells.
// Cell 0 is the head of the queue; each cell stores one task's id, its
// period and the ticks left relative to the cell before it.
// An item is taken when start is high and busy is low. Kind selects a tick,
// an add or a remove; the unused kind value gives a plain status-ok result.
// Each result appears on the rsp_ ports for one cycle, marked by rsp_valid,
// and is taken at the end of that cycle; the receiver cannot stall.
// Operations travel down the row as tokens, one cell per clock, so the
// time an item takes is set by how far its token walks:
//   add    : to the task's place, then on to the first free cell;
//   remove : to the task if found, as the gap closes up to the tail, else
//            to the first free cell, or off the end of a full row;
//   tick   : the head is decremented, then every task released is
//            popped from the head and walked back in.
// A full add or an unused kind answers in the cycle after it is taken and
// leaves busy low, so such items may follow back to back.
// A tick gives one result per released task with the last one flagged, or
// a single empty result when nothing falls due.
// Reset empties the queue at once: the occupancy bit of every cell and the
// task count are cleared, and the block is ready in the next cycle.
module periodic_release_delta_queue_core #(
   parameter int MAX_TASKS = prdq_pkg::MAX_TASKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [prdq_pkg::KIND_W-1:0]     req_kind,
   input  logic [prdq_pkg::TASK_W-1:0]     req_task_id,
   input  logic [prdq_pkg::DELTA_W-1:0]    req_first_delay,
   input  logic [prdq_pkg::DELTA_W-1:0]    req_period,
   output logic                            rsp_valid,
   output logic [prdq_pkg::TASK_W-1:0]     rsp_released_task,
   output logic                            rsp_released_valid,
   output logic [prdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_last
);
   import prdq_pkg::*;

   entry_type      ent   [MAX_TASKS];
   entry_type      nxt   [MAX_TASKS];
   token_type      tok_i [MAX_TASKS];
   token_type      tok_o [MAX_TASKS];
   chain_stat_type stat  [MAX_TASKS];
   token_type      launch;
   chain_stat_type chain_stat;

   // The controller injects every operation at the head cell.
   prdq_ctrl #(
      .MAX_TASKS (MAX_TASKS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_task_id        (req_task_id),
      .req_first_delay    (req_first_delay),
      .req_period         (req_period),
      .head               (ent[0]),
      .chain_stat         (chain_stat),
      .launch             (launch),
      .rsp_valid          (rsp_valid),
      .rsp_released_task  (rsp_released_task),
      .rsp_released_valid (rsp_released_valid),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

   // Each cell takes its token from the cell before it and looks at the
   // contents of the cell after it when entries close up on a removal.
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign tok_i[i] = launch;
      end else begin : g_body
         assign tok_i[i] = tok_o[i-1];
      end
      if (i == MAX_TASKS - 1) begin : g_tail
         assign nxt[i] = '0;
      end else begin : g_mid
         assign nxt[i] = ent[i+1];
      end
      prdq_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok_i[i]),
         .nxt     (nxt[i]),
         .ent     (ent[i]),
         .tok_out (tok_o[i]),
         .stat    (stat[i])
      );
   end

   // At most one cell holds a token, so the completion flags are simply
   // gathered. A search token leaving the last cell means the task is absent.
   always_comb begin
      chain_stat      = '0;
      chain_stat.miss = (tok_o[MAX_TASKS-1].kind == TOK_FIND);
      for (int i = 0; i < MAX_TASKS; i++) begin
         chain_stat.done = chain_stat.done | stat[i].done;
         chain_stat.miss = chain_stat.miss | stat[i].miss;
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Checks the periodic release queue by driving ticks, adds, removes and the
// unused kind through the start/busy command port. Every result strobe is
// checked against a delta-list predictor in this module, or a golden status.
module tb_top;
   import prdq_pkg::*;

   localparam int DEPTH         = MAX_TASKS_DEF;
   localparam int ITEM_COUNT    = 380;
   localparam int CYCLE_LIMIT   = 400000;
   // A tick releasing every task walks each one out and back in again.
   localparam int SETTLE_CYCLES = 4 * (DEPTH + 2) * DEPTH;

   typedef struct packed {
      logic [TASK_W-1:0] rel_task;
      logic              rel_valid;
      status_type        status;
      logic              last;
   } rsp_type;

   // One row of the directed table. Where golden is set, the result is known
   // at a glance and is checked against the typed status rather than the
   // predictor; the predictor still follows the row so that its state agrees.
   typedef struct packed {
      kind_type           kind;
      logic [TASK_W-1:0]  task_id;
      logic [DELTA_W-1:0] delay;
      logic [DELTA_W-1:0] period;
      logic               golden;
      status_type         golden_status;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [TASK_W-1:0]   req_task_id = '0;
   logic [DELTA_W-1:0]  req_first_delay = '0;
   logic [DELTA_W-1:0]  req_period = '0;
   logic                rsp_valid;
   logic [TASK_W-1:0]   rsp_released_task;
   logic                rsp_released_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;

   // Travels with the item on the request ports, so that the monitor sees
   // the tag of the item that is actually accepted at an edge.
   logic                cur_golden = 1'b0;
   status_type          cur_golden_status = STATUS_OK;

   // Predictor state: the release list in queue order, head at index 0.
   logic [TASK_W-1:0]   slot_id    [DEPTH];
   logic [DELTA_W-1:0]  slot_wait  [DEPTH];
   logic [DELTA_W-1:0]  slot_every [DEPTH];
   int                  queued = 0;

   rsp_type             awaited_rsp [$];
   int                  errors = 0;
   int                  cycles = 0;

   stim_row_type directed_rows [25] = '{
      // A tick on an empty queue releases nothing.
      '{KIND_TICK,   8'd0,   16'd0,     16'd0,     1'b1, STATUS_OK},
      '{KIND_REMOVE, 8'd5,   16'd1,     16'd1,     1'b1, STATUS_NOT_FOUND},
      '{KIND_NOP,    8'd255, 16'hFFFF,  16'hFFFF,  1'b1, STATUS_OK},
      // Zero delay and zero period are taken as one.
      '{KIND_ADD,    8'd0,   16'd0,     16'd0,     1'b1, STATUS_OK},
      '{KIND_ADD,    8'd255, 16'hFFFF,  16'hFFFF,  1'b1, STATUS_OK},
      '{KIND_ADD,    8'hAA,  16'd2,     16'd3,     1'b1, STATUS_OK},
      // Same release time as the previous task, so it must queue behind it.
      '{KIND_ADD,    8'h55,  16'd2,     16'd1,     1'b1, STATUS_OK},
      // A duplicate id is accepted without complaint.
      '{KIND_ADD,    8'hAA,  16'd5,     16'd2,     1'b1, STATUS_OK},
      '{KIND_ADD,    8'd7,   16'd1,     16'd4,     1'b1, STATUS_OK},
      '{KIND_ADD,    8'd8,   16'd3,     16'd2,     1'b1, STATUS_OK},
      '{KIND_ADD,    8'd9,   16'h8000,  16'h7FFF,  1'b1, STATUS_OK},
      // The queue now holds every slot.
      '{KIND_ADD,    8'd10,  16'd1,     16'd1,     1'b1, STATUS_FULL},
      '{KIND_TICK,   8'd0,   16'd0,     16'd0,     1'b0, STATUS_OK},
      '{KIND_TICK,   8'hFF,  16'hFFFF,  16'hFFFF,  1'b0, STATUS_OK},
      '{KIND_TICK,   8'd0,   16'd0,     16'd0,     1'b0, STATUS_OK},
      // Duplicates go one at a time, nearest the head first.
      '{KIND_REMOVE, 8'hAA,  16'd0,     16'd0,     1'b1, STATUS_OK},
      '{KIND_REMOVE, 8'hAA,  16'd0,     16'd0,     1'b1, STATUS_OK},
      '{KIND_REMOVE, 8'hAA,  16'd0,     16'd0,     1'b1, STATUS_NOT_FOUND},
      '{KIND_REMOVE, 8'd255, 16'd0,     16'd0,     1'b1, STATUS_OK},
      '{KIND_TICK,   8'd0,   16'd0,     16'd0,     1'b0, STATUS_OK},
      '{KIND_ADD,    8'd3,   16'd1,     16'hFFFF,  1'b1, STATUS_OK},
      '{KIND_TICK,   8'd0,   16'd0,     16'd0,     1'b0, STATUS_OK},
      '{KIND_REMOVE, 8'd9,   16'd0,     16'd0,     1'b1, STATUS_OK},
      '{KIND_REMOVE, 8'h5A,  16'd0,     16'd0,     1'b1, STATUS_NOT_FOUND},
      '{KIND_TICK,   8'd0,   16'd0,     16'd0,     1'b0, STATUS_OK}
   };

   periodic_release_delta_queue_core #(
      .MAX_TASKS(DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_task_id        (req_task_id),
      .req_first_delay    (req_first_delay),
      .req_period         (req_period),
      .rsp_valid          (rsp_valid),
      .rsp_released_task  (rsp_released_task),
      .rsp_released_valid (rsp_released_valid),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run is cut short if the block stops answering.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic rsp_type status_rsp(status_type status);
      return rsp_type'{8'd0, 1'b0, status, 1'b1};
   endfunction

   // Places a task at its point in release order. The walk subtracts each
   // earlier delta, and ties go behind the entries already due at that tick.
   function automatic void list_insert(logic [TASK_W-1:0] id, logic [DELTA_W-1:0] delay,
                                       logic [DELTA_W-1:0] per);
      int unsigned remaining;
      int          pos;
      remaining = delay;
      pos = 0;
      if (queued >= DEPTH) return;
      while (pos < queued && remaining >= slot_wait[pos]) begin
         remaining -= slot_wait[pos];
         pos++;
      end
      for (int i = queued; i > pos; i--) begin
         slot_id[i]    = slot_id[i-1];
         slot_wait[i]  = slot_wait[i-1];
         slot_every[i] = slot_every[i-1];
      end
      slot_id[pos]    = id;
      slot_wait[pos]  = DELTA_W'(remaining);
      slot_every[pos] = per;
      if (pos < queued) slot_wait[pos+1] = slot_wait[pos+1] - DELTA_W'(remaining);
      queued++;
   endfunction

   // Takes an entry out and hands its delta on to the one behind it, so that
   // later release times are kept.
   function automatic void list_unlink(int idx);
      if (idx >= queued) return;
      if (idx + 1 < queued) slot_wait[idx+1] = slot_wait[idx+1] + slot_wait[idx];
      for (int i = idx; i + 1 < queued; i++) begin
         slot_id[i]    = slot_id[i+1];
         slot_wait[i]  = slot_wait[i+1];
         slot_every[i] = slot_every[i+1];
      end
      queued--;
      slot_id[queued]    = '0;
      slot_wait[queued]  = '0;
      slot_every[queued] = '0;
   endfunction

   // Works out the results of one accepted item and queues them in order.
   function automatic void predict_release(kind_type kind, logic [TASK_W-1:0] id,
                                           logic [DELTA_W-1:0] delay,
                                           logic [DELTA_W-1:0] period);
      logic [DELTA_W-1:0] first_wait;
      logic [DELTA_W-1:0] every;
      logic [TASK_W-1:0]  due_id;
      logic [DELTA_W-1:0] due_every;
      int                 released;
      bit                 found;
      first_wait = (delay == 0) ? DELTA_W'(1) : delay;
      every      = (period == 0) ? DELTA_W'(1) : period;
      released   = 0;
      found      = 1'b0;
      case (kind)
         KIND_ADD: begin
            if (queued >= DEPTH) begin
               awaited_rsp.push_back(status_rsp(STATUS_FULL));
            end else begin
               list_insert(id, first_wait, every);
               awaited_rsp.push_back(status_rsp(STATUS_OK));
            end
         end
         KIND_REMOVE: begin
            for (int i = 0; i < queued && !found; i++) begin
               if (slot_id[i] == id) begin
                  list_unlink(i);
                  found = 1'b1;
               end
            end
            awaited_rsp.push_back(status_rsp(found ? STATUS_OK : STATUS_NOT_FOUND));
         end
         KIND_TICK: begin
            if (queued > 0 && slot_wait[0] > 0) slot_wait[0] = slot_wait[0] - 1'b1;
            while (queued > 0 && slot_wait[0] == 0 && released < DEPTH) begin
               due_id    = slot_id[0];
               due_every = (slot_every[0] == 0) ? DELTA_W'(1) : slot_every[0];
               list_unlink(0);
               list_insert(due_id, due_every, due_every);
               awaited_rsp.push_back(rsp_type'{due_id, 1'b1, STATUS_OK, 1'b0});
               released++;
            end
            if (released == 0) awaited_rsp.push_back(status_rsp(STATUS_OK));
            else awaited_rsp[awaited_rsp.size()-1].last = 1'b1;
         end
         default: begin
            awaited_rsp.push_back(status_rsp(STATUS_OK));
         end
      endcase
   endfunction

   function automatic void check_field(string name, int unsigned want, logic [TASK_W-1:0] got);
      if (got !== TASK_W'(want)) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // Monitor. Results are checked before the item taken at the same edge is
   // predicted, so a stray result can never be matched to a newer item.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               $error("released_task: expected no result, got %0d", rsp_released_task);
               errors++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("released_task", want.rel_task, rsp_released_task);
               check_field("released_valid", want.rel_valid, TASK_W'(rsp_released_valid));
               check_field("status", want.status, TASK_W'(rsp_status));
               check_field("last", want.last, TASK_W'(rsp_last));
            end
         end
         if (start && !busy) begin
            predict_release(kind_type'(req_kind), req_task_id, req_first_delay, req_period);
            if (cur_golden) begin
               void'(awaited_rsp.pop_back());
               awaited_rsp.push_back(status_rsp(cur_golden_status));
            end
         end
      end
   end

   // Presents one item and holds it until the edge at which it is taken.
   // Start is left high, so a caller that has another item ready simply
   // presents it at that same edge.
   task automatic send_item(kind_type kind, logic [TASK_W-1:0] id,
                            logic [DELTA_W-1:0] delay, logic [DELTA_W-1:0] period,
                            logic golden, status_type golden_status);
      start             <= 1'b1;
      req_kind          <= kind;
      req_task_id       <= id;
      req_first_delay   <= delay;
      req_period        <= period;
      cur_golden        <= golden;
      cur_golden_status <= golden_status;
      do @(posedge clock); while (!(start && !busy));
   endtask

   task automatic pause_sender(int gap);
      start <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   initial begin
      int                 counted;
      int                 burst;
      int                 pick;
      kind_type           kind;
      logic [TASK_W-1:0]  id;
      logic [DELTA_W-1:0] delay;
      logic [DELTA_W-1:0] period;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: walked row by row, sometimes back to back and
      // sometimes with a short gap.
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].kind, directed_rows[i].task_id, directed_rows[i].delay,
                   directed_rows[i].period, directed_rows[i].golden,
                   directed_rows[i].golden_status);
         if ($urandom_range(2) == 0) pause_sender($urandom_range(1, 3));
      end

      // Hold off until the queue has answered everything outstanding; waiting
      // starts once the last item taken has been predicted.
      start <= 1'b0;
      @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      @(posedge clock);

      // Random part: ticks dominate so that tasks actually fall due; short
      // delays and periods keep the releases frequent, while the odd full
      // range value and the unused kind keep the rest of the input space in.
      counted = $size(directed_rows);
      while (counted < ITEM_COUNT) begin
         burst = ($urandom_range(7) == 0) ? 40 : $urandom_range(1, 10);
         if (burst > ITEM_COUNT - counted) burst = ITEM_COUNT - counted;
         repeat (burst) begin
            pick   = $urandom_range(99);
            id     = ($urandom_range(1) == 0) ? TASK_W'($urandom_range(15))
                                              : TASK_W'($urandom_range(255));
            delay  = ($urandom_range(4) == 0) ? DELTA_W'($urandom_range(65535))
                                              : DELTA_W'($urandom_range(1, 12));
            period = ($urandom_range(6) == 0) ? DELTA_W'($urandom_range(65535))
                                              : DELTA_W'($urandom_range(1, 10));
            if (pick < 45) begin
               kind = KIND_TICK;
            end else if (pick < 75) begin
               kind = KIND_ADD;
            end else if (pick < 93) begin
               kind = KIND_REMOVE;
               // Mostly a task that is queued now, so removals really happen.
               if (queued > 0 && $urandom_range(3) != 0)
                  id = slot_id[$urandom_range(queued - 1)];
            end else begin
               kind = KIND_NOP;
            end
            send_item(kind, id, delay, period, 1'b0, STATUS_OK);
            counted++;
         end
         if ($urandom_range(24) == 0) begin
            start <= 1'b0;
            @(posedge clock);
            while (awaited_rsp.size() != 0) @(posedge clock);
         end else begin
            pause_sender($urandom_range(1, 12));
         end
      end

      // Let the last results drain, then watch a while longer for strays.
      start <= 1'b0;
      @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
